FILE: rtl/lower_convex_hull_stack_unit_assert.svh
// Assertion macros for the hull stack RTL.
`ifndef LOWER_CONVEX_HULL_STACK_UNIT_ASSERT_SVH
`define LOWER_CONVEX_HULL_STACK_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define HULL_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("hull stack assertion failed");

`define HULL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hull stack assertion failed");

`define HULL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hull stack assertion failed");

`else

`define HULL_ASSERT_ALWAYS(lbl, expr)
`define HULL_ASSERT_IMPL(lbl, ante, cons)
`define HULL_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/lchs_pkg.sv
`default_nettype none

package lchs_pkg;

    localparam int HULL_DEPTH_DEF = 1024;
    localparam int X_WIDTH_DEF    = 20;
    localparam int Y_WIDTH_DEF    = 48;

    localparam int ACTION_W    = 2;
    localparam int INDEX_W     = 10;
    localparam int COUNT_OUT_W = 11;
    localparam int STATUS_W    = 2;
    localparam int CHUNK_W     = 32;

    localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ORDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic done;
        logic left;
    } lchs_cross_stat_t;

endpackage

`default_nettype wire

FILE: rtl/lchs_ram.sv
`default_nettype none

module lchs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/lchs_cross.sv
`default_nettype none

module lchs_cross #(
    parameter int X_WIDTH = lchs_pkg::X_WIDTH_DEF,
    parameter int Y_WIDTH = lchs_pkg::Y_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic        [X_WIDTH-1:0]   px,
    input  wire logic signed [Y_WIDTH-1:0]   py,
    input  wire logic        [X_WIDTH-1:0]   qx,
    input  wire logic signed [Y_WIDTH-1:0]   qy,
    input  wire logic        [X_WIDTH-1:0]   rx,
    input  wire logic signed [Y_WIDTH-1:0]   ry,
    output lchs_pkg::lchs_cross_stat_t       stat
);

    import lchs_pkg::*;

    localparam int DY_W   = Y_WIDTH + 1;
    localparam int NCH    = (DY_W + CHUNK_W - 1) / CHUNK_W;
    localparam int MAG_W  = NCH * CHUNK_W;
    localparam int KW     = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PROD_W = CHUNK_W + X_WIDTH;
    localparam int ACC_W  = Y_WIDTH + X_WIDTH + 3;

    logic signed [DY_W-1:0]   dya;
    logic signed [DY_W-1:0]   dyb;
    logic        [DY_W-1:0]   mag_a;
    logic        [DY_W-1:0]   mag_b;

    logic [MAG_W-1:0]   mag_a_reg;
    logic [MAG_W-1:0]   mag_b_reg;
    logic               neg_a_reg;
    logic               neg_b_reg;
    logic [X_WIDTH-1:0] d_a_reg;
    logic [X_WIDTH-1:0] d_b_reg;

    logic               busy_reg;
    logic               job_reg;
    logic [KW-1:0]      k_reg;
    logic               prod_vld_reg;
    logic               fin_reg;

    logic [PROD_W-1:0]  prod_reg;
    logic               prod_neg_reg;
    logic [KW-1:0]      prod_k_reg;
    logic               prod_last_reg;
    logic [ACC_W-1:0]   acc_reg;

    logic [MAG_W-1:0]   mag_cur;
    logic [CHUNK_W-1:0] chunk;
    logic [X_WIDTH-1:0] d_cur;
    logic               neg_cur;
    logic               k_wrap;
    logic               last_issue;
    logic [ACC_W-1:0]   term;

    always_comb
    begin
        dya   = {ry[Y_WIDTH-1], ry} - {py[Y_WIDTH-1], py};
        dyb   = {qy[Y_WIDTH-1], qy} - {py[Y_WIDTH-1], py};
        mag_a = dya[DY_W-1] ? (DY_W'(0) - dya) : dya;
        mag_b = dyb[DY_W-1] ? (DY_W'(0) - dyb) : dyb;

        mag_cur    = job_reg ? mag_b_reg : mag_a_reg;
        d_cur      = job_reg ? d_b_reg : d_a_reg;
        neg_cur    = job_reg ? neg_b_reg : neg_a_reg;
        chunk      = mag_cur[k_reg*CHUNK_W +: CHUNK_W];
        k_wrap     = (k_reg == KW'(NCH - 1));
        last_issue = job_reg && k_wrap;
        term       = ACC_W'(prod_reg) << (prod_k_reg * CHUNK_W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            job_reg      <= 1'b0;
            k_reg        <= '0;
            prod_vld_reg <= 1'b0;
            fin_reg      <= 1'b0;
        end
        else
        begin
            fin_reg      <= prod_vld_reg && prod_last_reg;
            prod_vld_reg <= busy_reg;
            if (start)
            begin
                busy_reg <= 1'b1;
                job_reg  <= 1'b0;
                k_reg    <= '0;
            end
            else if (busy_reg)
            begin
                if (k_wrap)
                begin
                    k_reg   <= '0;
                    job_reg <= 1'b1;
                end
                else
                begin
                    k_reg <= k_reg + KW'(1);
                end
                if (last_issue)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_a_reg <= MAG_W'(mag_a);
            mag_b_reg <= MAG_W'(mag_b);
            neg_a_reg <= dya[DY_W-1];
            neg_b_reg <= !dyb[DY_W-1];
            d_a_reg   <= qx - px;
            d_b_reg   <= rx - px;
            acc_reg   <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= prod_neg_reg ? (acc_reg - term) : (acc_reg + term);
        end
        prod_reg      <= PROD_W'(chunk) * PROD_W'(d_cur);
        prod_neg_reg  <= neg_cur;
        prod_k_reg    <= k_reg;
        prod_last_reg <= last_issue;
    end

    assign stat.done = fin_reg;
    assign stat.left = !acc_reg[ACC_W-1] && (acc_reg != '0);

endmodule

`default_nettype wire

FILE: rtl/lower_convex_hull_stack_unit.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+-------------------------------------------
// input    | in_valid / in_ready    | action, px, py, vertex_index
// output   | out_valid / out_ready  | hull_count, vertex_x, vertex_y, status
//
// One request at a time; in_ready is high only while the sequencer is idle.
// Clear and unused action go straight to the response. Read: memory read and wait state, or
// straight to the response when the index is beyond the count. Push, if the hull is not empty:
// top vertex read, then for each turn test a read of the second vertex and the chunked
// multiply-accumulate on the shared unit. The single-port read of the vertex memory and the
// one 32 x X_WIDTH multiplier set this sequence. A finished result waits in the output
// register while the next request is taken. Reset empties the hull at once; no clearing pass.
`default_nettype none

`include "lower_convex_hull_stack_unit_assert.svh"

module lower_convex_hull_stack_unit #(
    parameter int HULL_DEPTH = lchs_pkg::HULL_DEPTH_DEF,
    parameter int X_WIDTH    = lchs_pkg::X_WIDTH_DEF,
    parameter int Y_WIDTH    = lchs_pkg::Y_WIDTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic        [lchs_pkg::ACTION_W-1:0]  action,
    input  wire logic        [X_WIDTH-1:0]             px,
    input  wire logic signed [Y_WIDTH-1:0]             py,
    input  wire logic        [lchs_pkg::INDEX_W-1:0]   vertex_index,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic        [lchs_pkg::COUNT_OUT_W-1:0]    hull_count,
    output logic        [X_WIDTH-1:0]                  vertex_x,
    output logic signed [Y_WIDTH-1:0]                  vertex_y,
    output logic        [lchs_pkg::STATUS_W-1:0]       status
);

    import lchs_pkg::*;

    localparam int ADDR_W = $clog2(HULL_DEPTH);
    localparam int CNT_W  = $clog2(HULL_DEPTH + 1);
    localparam int MEM_W  = X_WIDTH + Y_WIDTH;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_READ      = 10'b00_0000_0010,
        S_READ_WAIT = 10'b00_0000_0100,
        S_TOP       = 10'b00_0000_1000,
        S_TOP_WAIT  = 10'b00_0001_0000,
        S_SEC       = 10'b00_0010_0000,
        S_SEC_WAIT  = 10'b00_0100_0000,
        S_CROSS     = 10'b00_1000_0000,
        S_PUSH      = 10'b01_0000_0000,
        S_RESP      = 10'b10_0000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;

    logic        [X_WIDTH-1:0]  x_reg, x_next;
    logic signed [Y_WIDTH-1:0]  y_reg, y_next;
    logic        [INDEX_W-1:0]  idx_reg, idx_next;
    logic        [X_WIDTH-1:0]  top_x_reg, top_x_next;
    logic signed [Y_WIDTH-1:0]  top_y_reg, top_y_next;
    logic        [X_WIDTH-1:0]  sec_x_reg, sec_x_next;
    logic signed [Y_WIDTH-1:0]  sec_y_reg, sec_y_next;
    logic        [STATUS_W-1:0] st_reg, st_next;
    logic        [X_WIDTH-1:0]  vx_reg, vx_next;
    logic signed [Y_WIDTH-1:0]  vy_reg, vy_next;

    logic        [COUNT_OUT_W-1:0] out_count_reg, out_count_next;
    logic        [X_WIDTH-1:0]     out_x_reg, out_x_next;
    logic signed [Y_WIDTH-1:0]     out_y_reg, out_y_next;
    logic        [STATUS_W-1:0]    out_st_reg, out_st_next;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [MEM_W-1:0]       ram_rdata;
    logic        [X_WIDTH-1:0] rd_x;
    logic signed [Y_WIDTH-1:0] rd_y;

    logic                   cross_start;
    lchs_cross_stat_t       cross_stat;
    logic                   resp_load;

    assign rd_x = ram_rdata[MEM_W-1 -: X_WIDTH];
    assign rd_y = ram_rdata[Y_WIDTH-1:0];

    lchs_ram #(
        .WIDTH (MEM_W),
        .DEPTH (HULL_DEPTH)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({x_reg, y_reg}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lchs_cross #(
        .X_WIDTH (X_WIDTH),
        .Y_WIDTH (Y_WIDTH)
    ) u_cross (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cross_start),
        .px    (rd_x),
        .py    (rd_y),
        .qx    (top_x_reg),
        .qy    (top_y_reg),
        .rx    (x_reg),
        .ry    (y_reg),
        .stat  (cross_stat)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign resp_load = (state_reg == S_RESP) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        idx_next       = idx_reg;
        top_x_next     = top_x_reg;
        top_y_next     = top_y_reg;
        sec_x_next     = sec_x_reg;
        sec_y_next     = sec_y_reg;
        st_next        = st_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        out_count_next = out_count_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_st_next    = out_st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ram_we         = 1'b0;
        ram_waddr      = ADDR_W'(count_reg);
        ram_raddr      = '0;
        cross_start    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next   = px;
                    y_next   = py;
                    idx_next = vertex_index;
                    st_next  = ST_OK;
                    vx_next  = '0;
                    vy_next  = '0;
                    case (action)
                        ACT_PUSH:
                        begin
                            state_next = (count_reg == '0) ? S_PUSH : S_TOP;
                        end
                        ACT_READ:
                        begin
                            if (32'(vertex_index) < 32'(count_reg))
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                st_next    = ST_RANGE;
                                state_next = S_RESP;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                ram_raddr  = ADDR_W'(idx_reg);
                state_next = S_READ_WAIT;
            end
            S_READ_WAIT:
            begin
                vx_next    = rd_x;
                vy_next    = rd_y;
                state_next = S_RESP;
            end
            S_TOP:
            begin
                ram_raddr  = ADDR_W'(count_reg - CNT_W'(1));
                state_next = S_TOP_WAIT;
            end
            S_TOP_WAIT:
            begin
                top_x_next = rd_x;
                top_y_next = rd_y;
                if ((x_reg < rd_x) || ((x_reg == rd_x) && (y_reg < rd_y)))
                begin
                    st_next    = ST_ORDER;
                    state_next = S_RESP;
                end
                else if (count_reg >= CNT_W'(2))
                begin
                    state_next = S_SEC;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_SEC:
            begin
                ram_raddr  = ADDR_W'(count_reg - CNT_W'(2));
                state_next = S_SEC_WAIT;
            end
            S_SEC_WAIT:
            begin
                sec_x_next  = rd_x;
                sec_y_next  = rd_y;
                cross_start = 1'b1;
                state_next  = S_CROSS;
            end
            S_CROSS:
            begin
                if (cross_stat.done)
                begin
                    if (cross_stat.left)
                    begin
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        top_x_next = sec_x_reg;
                        top_y_next = sec_y_reg;
                        state_next = (count_reg >= CNT_W'(3)) ? S_SEC : S_PUSH;
                    end
                end
            end
            S_PUSH:
            begin
                if (32'(count_reg) >= HULL_DEPTH)
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (resp_load)
                begin
                    out_count_next = COUNT_OUT_W'(count_reg);
                    out_x_next     = vx_reg;
                    out_y_next     = vy_reg;
                    out_st_next    = st_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        idx_reg       <= idx_next;
        top_x_reg     <= top_x_next;
        top_y_reg     <= top_y_next;
        sec_x_reg     <= sec_x_next;
        sec_y_reg     <= sec_y_next;
        st_reg        <= st_next;
        vx_reg        <= vx_next;
        vy_reg        <= vy_next;
        out_count_reg <= out_count_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_st_reg    <= out_st_next;
    end

    assign out_valid  = out_valid_reg;
    assign hull_count = out_count_reg;
    assign vertex_x   = out_x_reg;
    assign vertex_y   = out_y_reg;
    assign status     = out_st_reg;

    `HULL_ASSERT_ALWAYS(a_count_max, 32'(count_reg) <= HULL_DEPTH)
    `HULL_ASSERT_IMPL(a_write_room, ram_we, (state_reg == S_PUSH) && (32'(count_reg) < HULL_DEPTH))
    `HULL_ASSERT_IMPL(a_cross_done, cross_stat.done, state_reg == S_CROSS)
    `HULL_ASSERT_NEXT(a_busy_after_request, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire

FILE: verif/lchs_hull_checker.sv
`timescale 1ns / 100ps

module lchs_hull_checker (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    input  wire logic                                   in_ready,
    input  wire logic        [lchs_pkg::ACTION_W-1:0]   action,
    input  wire logic        [lchs_pkg::X_WIDTH_DEF-1:0] px,
    input  wire logic signed [lchs_pkg::Y_WIDTH_DEF-1:0] py,
    input  wire logic        [lchs_pkg::INDEX_W-1:0]    vertex_index,
    input  wire logic                                   out_valid,
    input  wire logic                                   out_ready,
    input  wire logic        [lchs_pkg::COUNT_OUT_W-1:0] hull_count,
    input  wire logic        [lchs_pkg::X_WIDTH_DEF-1:0] vertex_x,
    input  wire logic signed [lchs_pkg::Y_WIDTH_DEF-1:0] vertex_y,
    input  wire logic        [lchs_pkg::STATUS_W-1:0]   status,
    output int                                          mismatches,
    output int                                          pending
);

    import lchs_pkg::*;

    localparam int XW    = X_WIDTH_DEF;
    localparam int YW    = Y_WIDTH_DEF;
    localparam int DEPTH = HULL_DEPTH_DEF;

    typedef struct packed {
        logic        [COUNT_OUT_W-1:0] count;
        logic        [XW-1:0]          vx;
        logic signed [YW-1:0]          vy;
        logic        [STATUS_W-1:0]    code;
    } hull_result_t;

    logic        [XW-1:0] corner_x [DEPTH];
    logic signed [YW-1:0] corner_y [DEPTH];
    int                   hull_size;
    int                   wrong = 0;
    hull_result_t         awaited_q [$];

    function automatic bit left_turn(
        input logic        [XW-1:0] ax,
        input logic signed [YW-1:0] ay,
        input logic        [XW-1:0] bx,
        input logic signed [YW-1:0] by,
        input logic        [XW-1:0] cx,
        input logic signed [YW-1:0] cy
    );
        logic signed [127:0] run_b, run_c, rise_b, rise_c, turn_val;
        run_b  = $signed({{(128-XW){1'b0}}, bx}) - $signed({{(128-XW){1'b0}}, ax});
        run_c  = $signed({{(128-XW){1'b0}}, cx}) - $signed({{(128-XW){1'b0}}, ax});
        rise_b = by;
        rise_b = rise_b - ay;
        rise_c = cy;
        rise_c = rise_c - ay;
        turn_val = rise_c * run_b - rise_b * run_c;
        return turn_val > 0;
    endfunction

    function automatic hull_result_t apply_request(
        input logic        [ACTION_W-1:0] act,
        input logic        [XW-1:0]       x,
        input logic signed [YW-1:0]       y,
        input logic        [INDEX_W-1:0]  idx
    );
        hull_result_t r;
        r = '0;
        case (act)
            ACT_PUSH: begin
                if (hull_size > 0 && (x < corner_x[hull_size-1] ||
                    (x == corner_x[hull_size-1] && y < corner_y[hull_size-1]))) begin
                    r.code = ST_ORDER;
                end
                else begin
                    while (hull_size >= 2 &&
                           !left_turn(corner_x[hull_size-2], corner_y[hull_size-2],
                                      corner_x[hull_size-1], corner_y[hull_size-1], x, y))
                        hull_size--;
                    if (hull_size >= DEPTH) begin
                        r.code = ST_FULL;
                    end
                    else begin
                        corner_x[hull_size] = x;
                        corner_y[hull_size] = y;
                        hull_size++;
                    end
                end
            end
            ACT_READ: begin
                if (int'(idx) < hull_size) begin
                    r.vx = corner_x[idx];
                    r.vy = corner_y[idx];
                end
                else begin
                    r.code = ST_RANGE;
                end
            end
            ACT_CLEAR: hull_size = 0;
            default: ;
        endcase
        r.count = COUNT_OUT_W'(hull_size);
        return r;
    endfunction

    task automatic flag(input string field, input longint want, input longint got);
        wrong++;
        $error("%s: expected %0d, actual %0d", field, want, got);
    endtask

    always @(posedge clk or negedge rst_n) begin
        hull_result_t seen;
        if (!rst_n) begin
            hull_size = 0;
            awaited_q.delete();
            pending <= 0;
        end
        else begin
            if (in_valid && in_ready)
                awaited_q.push_back(apply_request(action, px, py, vertex_index));
            if (out_valid && out_ready) begin
                if (awaited_q.size() == 0) begin
                    flag("hull_count (no request pending)", -1, hull_count);
                end
                else begin
                    seen = awaited_q.pop_front();
                    if (hull_count !== seen.count)
                        flag("hull_count", seen.count, hull_count);
                    if (vertex_x !== seen.vx)
                        flag("vertex_x", seen.vx, vertex_x);
                    if (vertex_y !== seen.vy)
                        flag("vertex_y", seen.vy, vertex_y);
                    if (status !== seen.code)
                        flag("status", seen.code, status);
                end
            end
            pending <= awaited_q.size();
        end
        mismatches <= wrong;
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;

    import lchs_pkg::*;

    localparam int XW    = X_WIDTH_DEF;
    localparam int YW    = Y_WIDTH_DEF;
    localparam int DEPTH = HULL_DEPTH_DEF;

    localparam logic        [XW-1:0] X_MAX = {XW{1'b1}};
    localparam logic signed [YW-1:0] Y_MAX = {1'b0, {(YW-1){1'b1}}};
    localparam logic signed [YW-1:0] Y_MIN = {1'b1, {(YW-1){1'b0}}};

    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

    localparam int RANDOM_REQUESTS = 1600;
    localparam int CALM_TAIL       = 150;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 100000;
    localparam int SETTLE_CYCLES   = 20;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic        [ACTION_W-1:0] action;
    logic        [XW-1:0]       px;
    logic signed [YW-1:0]       py;
    logic        [INDEX_W-1:0]  vertex_index;
    logic                       out_valid;
    logic                       out_ready;
    logic        [COUNT_OUT_W-1:0] hull_count;
    logic        [XW-1:0]       vertex_x;
    logic signed [YW-1:0]       vertex_y;
    logic        [STATUS_W-1:0] status;

    int check_failures;
    int results_pending;

    bit calm          = 1'b0;
    bit hold_off_req  = 1'b0;
    int requests_sent = 0;

    logic        [XW-1:0] cur_x;
    logic signed [YW-1:0] cur_y;

    lower_convex_hull_stack_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .px           (px),
        .py           (py),
        .vertex_index (vertex_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hull_count   (hull_count),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .status       (status)
    );

    lchs_hull_checker hull_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .px           (px),
        .py           (py),
        .vertex_index (vertex_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hull_count   (hull_count),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .status       (status),
        .mismatches   (check_failures),
        .pending      (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic signed [YW-1:0] rand_y();
        return YW'({$urandom, $urandom});
    endfunction

    task automatic offer_request(
        input logic        [ACTION_W-1:0] act,
        input logic        [XW-1:0]       x,
        input logic signed [YW-1:0]       y,
        input logic        [INDEX_W-1:0]  idx
    );
        in_valid     <= 1'b1;
        action       <= act;
        px           <= x;
        py           <= y;
        vertex_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18))
                @(posedge clk);
        end
    endtask

    task automatic push_point(input logic [XW-1:0] x, input logic signed [YW-1:0] y);
        cur_x = x;
        cur_y = y;
        offer_request(ACT_PUSH, x, y, INDEX_W'($urandom));
    endtask

    task automatic read_vertex(input logic [INDEX_W-1:0] idx);
        offer_request(ACT_READ, XW'($urandom), rand_y(), idx);
    endtask

    task automatic clear_hull();
        cur_x = '0;
        cur_y = Y_MIN;
        offer_request(ACT_CLEAR, XW'($urandom), rand_y(), INDEX_W'($urandom));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
    endtask

    // Mostly ascending points with random content, plus reads and some noise.
    task automatic chain_burst();
        int          n;
        int          pushes;
        longint      slope;
        longint      ny;
        logic [XW:0] nx;
        pushes = 0;
        if ($urandom_range(0, 3) != 0)
        begin
            clear_hull();
            case ($urandom_range(0, 3))
                0: cur_x = '0;
                1: cur_x = X_MAX - XW'($urandom_range(0, 5000));
                default: cur_x = XW'($urandom);
            endcase
            if ($urandom_range(0, 1) == 0)
                cur_y = rand_y();
            else
                cur_y = YW'(longint'($urandom_range(0, 2000000)) - 1000000);
        end
        slope = longint'($urandom_range(0, 2000000000)) - 1000000000;
        n = $urandom_range(4, 40);
        repeat (n)
        begin
            case ($urandom_range(0, 19))
                12, 13, 14, 15:
                begin
                    if ($urandom_range(0, 3) == 0)
                        read_vertex(INDEX_W'($urandom));
                    else
                        read_vertex(INDEX_W'($urandom_range(0, pushes + 1)));
                end
                16: offer_request(ACT_PUSH, XW'($urandom_range(0, cur_x)), rand_y(),
                                  INDEX_W'($urandom));
                17: offer_request(ACT_SPARE, XW'($urandom), rand_y(), INDEX_W'($urandom));
                18: offer_request(ACT_PUSH, XW'($urandom), rand_y(), INDEX_W'($urandom));
                19:
                begin
                    clear_hull();
                    pushes = 0;
                end
                default:
                begin
                    case ($urandom_range(0, 7))
                        0: nx = cur_x;
                        1: nx = cur_x + $urandom_range(1, 1 << 16);
                        default: nx = cur_x + $urandom_range(1, 16);
                    endcase
                    if (nx > X_MAX)
                        nx = X_MAX;
                    if (nx[XW-1:0] == cur_x)
                        ny = longint'(cur_y) + $urandom_range(0, 1000);
                    else if ($urandom_range(0, 2) == 0)
                        ny = longint'(rand_y());
                    else
                    begin
                        slope += $urandom_range(0, 65536);
                        ny = longint'(cur_y) + slope * longint'(nx - cur_x);
                    end
                    if (ny > longint'(Y_MAX))
                        ny = Y_MAX;
                    if (ny < longint'(Y_MIN))
                        ny = Y_MIN;
                    push_point(nx[XW-1:0], YW'(ny));
                    pushes++;
                end
            endcase
        end
    endtask

    // Strictly convex chain two points past capacity, then one point that pops nearly all.
    task automatic fill_hull();
        int     bend;
        longint slope;
        clear_hull();
        push_point(XW'($urandom_range(0, X_MAX - 1100)),
                   YW'(longint'($urandom_range(0, 1 << 30)) - (1 << 29)));
        bend  = $urandom_range(1, 1000);
        slope = longint'($urandom_range(0, 1 << 20)) - (1 << 19) - longint'(bend) * 512;
        repeat (DEPTH + 1)
        begin
            slope += bend;
            push_point(cur_x + 1'b1, YW'(longint'(cur_y) + slope));
        end
        read_vertex(INDEX_W'(DEPTH - 1));
        read_vertex('0);
        read_vertex(INDEX_W'($urandom));
        push_point(cur_x + 1'b1, Y_MIN);
        read_vertex(INDEX_W'(1));
        read_vertex(INDEX_W'(2));
    endtask

    initial
    begin
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES)
                    @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18))
                    @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 40))
                @(posedge clk);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        int base;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        action       <= ACT_PUSH;
        px           <= '0;
        py           <= '0;
        vertex_index <= '0;
        cur_x = '0;
        cur_y = Y_MIN;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        read_vertex('0);
        offer_request(ACT_SPARE, X_MAX, Y_MAX, '1);
        push_point('0, Y_MIN);
        push_point('0, Y_MIN);
        push_point(XW'(5), '0);
        offer_request(ACT_PUSH, XW'(3), '0, '0);
        offer_request(ACT_PUSH, XW'(5), -1, '0);
        push_point(X_MAX, Y_MAX);
        read_vertex('0);
        read_vertex(INDEX_W'(1));
        read_vertex(INDEX_W'(2));
        read_vertex('1);
        clear_hull();
        push_point('0, '0);
        push_point(XW'(10), YW'(10));
        push_point(XW'(20), YW'(20));
        push_point(XW'(30), YW'(100));
        read_vertex(INDEX_W'(1));
        clear_hull();
        push_point(X_MAX, Y_MAX);
        offer_request(ACT_PUSH, X_MAX, Y_MIN, '0);
        push_point(X_MAX, Y_MAX);
        read_vertex('0);
        clear_hull();

        base = requests_sent;
        while (requests_sent < base + 250)
            chain_burst();
        hold_off_req = 1'b1;
        chain_burst();
        chain_burst();
        fill_hull();
        drain_results();
        while (requests_sent < base + RANDOM_REQUESTS - CALM_TAIL)
            chain_burst();
        calm = 1'b1;
        while (requests_sent < base + RANDOM_REQUESTS)
            chain_burst();

        drain_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (check_failures == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
